// File: hw/rtl/taqe_pkg.sv
// shared constants and codes for the tree ancestor query engine
package taqe_pkg;

  // default tree size and jump levels
  localparam int NODES_DEF  = 1024;
  localparam int LEVELS_DEF = 10;

  // fixed field widths
  localparam int ID_W    = 10;
  localparam int KIND_W  = 2;
  localparam int DEPTH_W = 10;
  localparam int DIST_W  = 11;

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_ROOT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ATTACH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  // deepest depth a node can carry
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;

  // child depth from parent depth, saturating
  function automatic logic [DEPTH_W-1:0] depth_inc(input logic [DEPTH_W-1:0] d);
    depth_inc = (d == DEPTH_MAX) ? DEPTH_MAX : d + 1'b1;
  endfunction

endpackage

// File: hw/rtl/tree_ancestor_query_engine.sv
// top level: binary lifting ancestor engine with depth and jump memories
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  in_     | in  | in_tvalid/tready   | tuser: kind; tdata: node_a, node_b
//  out_    | out | out_tvalid/tready  | tdata: common_ancestor, distance
//
//  one item at a time; a result sits in the output register while the next item runs
//  query run time is set by the dependent reads of the jump memory
//  (one read round trip per jump)
//  when NODES < 1024 every item first passes through modulo reduction
//  synchronous active-low reset clears control only; tables are undefined until written
//  a stalled output delays the handoff of the next finished result and so the next input
module tree_ancestor_query_engine #(
  parameter int NODES  = taqe_pkg::NODES_DEF,
  parameter int LEVELS = taqe_pkg::LEVELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [taqe_pkg::IN_TDATA_W-1:0]    in_tdata,   // node_a[9:0], node_b[19:10]
  input  logic [taqe_pkg::KIND_W-1:0]        in_tuser,   // kind[1:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [taqe_pkg::OUT_TDATA_W-1:0]   out_tdata   // common_ancestor[9:0], distance[20:10]
);
  import taqe_pkg::*;

  localparam int  NW      = $clog2(NODES);
  localparam int  LW      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int  JAW     = NW + LW;
  localparam bit  NEED_RED = (NODES < 1024);
  localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

  // sequencer states
  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_RED       = 5'd1;
  localparam logic [4:0] S_DISP      = 5'd2;
  localparam logic [4:0] S_ROOT      = 5'd3;
  localparam logic [4:0] S_ATT_DEP   = 5'd4;
  localparam logic [4:0] S_ATT_RD    = 5'd5;
  localparam logic [4:0] S_ATT_WR    = 5'd6;
  localparam logic [4:0] S_Q_DA      = 5'd7;
  localparam logic [4:0] S_Q_DB      = 5'd8;
  localparam logic [4:0] S_Q_LIFT    = 5'd9;
  localparam logic [4:0] S_Q_LIFT_WT = 5'd10;
  localparam logic [4:0] S_Q_CMP     = 5'd11;
  localparam logic [4:0] S_Q_DESC    = 5'd12;
  localparam logic [4:0] S_Q_DESC_WT = 5'd13;
  localparam logic [4:0] S_Q_ANC     = 5'd14;
  localparam logic [4:0] S_Q_ANC_WT  = 5'd15;
  localparam logic [4:0] S_Q_DEP     = 5'd16;
  localparam logic [4:0] S_Q_DIST    = 5'd17;
  localparam logic [4:0] S_DONE      = 5'd18;

  // control registers
  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // payload registers
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [ID_W-1:0]    ra_r, ra_nxt;
  logic [ID_W-1:0]    rb_r, rb_nxt;
  logic [3:0]         red_s_r, red_s_nxt;
  logic [LW-1:0]      lvl_r, lvl_nxt;
  logic [NW-1:0]      cur_r, cur_nxt;
  logic [NW-1:0]      x_r, x_nxt;
  logic [NW-1:0]      y_r, y_nxt;
  logic [NW-1:0]      anc_r, anc_nxt;
  logic [LEVELS-1:0]  k_r, k_nxt;
  logic [DEPTH_W-1:0] da_r, da_nxt;
  logic [DEPTH_W-1:0] db_r, db_nxt;
  logic [ID_W-1:0]    res_anc_r, res_anc_nxt;
  logic [DIST_W-1:0]  res_dist_r, res_dist_nxt;
  logic [ID_W-1:0]    out_anc_r, out_anc_nxt;
  logic [DIST_W-1:0]  out_dist_r, out_dist_nxt;

  // memory controls
  logic               jwe;
  logic [JAW-1:0]     jwa;
  logic [NW-1:0]      jwd;
  logic [JAW-1:0]     jra_a, jra_b;
  logic [NW-1:0]      jrd_a, jrd_b;
  logic               dwe;
  logic [NW-1:0]      dwa;
  logic [DEPTH_W-1:0] dwd;
  logic [NW-1:0]      dra;
  logic [DEPTH_W-1:0] drd_r;
  logic [DEPTH_W-1:0] dmem [0:NODES-1];

  // reduced node numbers and helpers
  logic [NW-1:0]      na, nb;
  logic [ID_W-1:0]    ra_red, rb_red;
  logic [19:0]        thr_hi, thr_lo;
  logic [DIST_W-1:0]  dsum, dtwice;
  logic               out_free;

  assign na       = NW'(ra_r);
  assign nb       = NW'(rb_r);
  assign out_free = !out_valid_r || out_tready;

  // two restoring steps of the node modulo per cycle
  always_comb begin
    ra_red = ra_r;
    rb_red = rb_r;
    thr_hi = 20'(NODES) << red_s_r;
    thr_lo = 20'(NODES) << (red_s_r - 1'b1);
    if (20'(ra_red) >= thr_hi) ra_red = ra_red - ID_W'(thr_hi);
    if (20'(rb_red) >= thr_hi) rb_red = rb_red - ID_W'(thr_hi);
    if (20'(ra_red) >= thr_lo) ra_red = ra_red - ID_W'(thr_lo);
    if (20'(rb_red) >= thr_lo) rb_red = rb_red - ID_W'(thr_lo);
  end

  // path length from the three depths, clamped at zero
  assign dsum   = {1'b0, da_r} + {1'b0, db_r};
  assign dtwice = {drd_r, 1'b0};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    red_s_nxt     = red_s_r;
    lvl_nxt       = lvl_r;
    cur_nxt       = cur_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    anc_nxt       = anc_r;
    k_nxt         = k_r;
    da_nxt        = da_r;
    db_nxt        = db_r;
    res_anc_nxt   = res_anc_r;
    res_dist_nxt  = res_dist_r;
    out_anc_nxt   = out_anc_r;
    out_dist_nxt  = out_dist_r;
    jwe   = 1'b0;
    jwa   = '0;
    jwd   = '0;
    jra_a = '0;
    jra_b = '0;
    dwe   = 1'b0;
    dwa   = '0;
    dwd   = '0;
    dra   = '0;

    // output register drains independently
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt     = in_tuser;
          ra_nxt       = in_tdata[9:0];
          rb_nxt       = in_tdata[19:10];
          red_s_nxt    = 4'd9;
          res_anc_nxt  = '0;
          res_dist_nxt = '0;
          state_nxt    = NEED_RED ? S_RED : S_DISP;
        end
      end
      S_RED: begin
        ra_nxt    = ra_red;
        rb_nxt    = rb_red;
        red_s_nxt = red_s_r - 4'd2;
        if (red_s_r == 4'd1) state_nxt = S_DISP;
      end
      S_DISP: begin
        case (kind_r)
          KIND_ROOT: begin
            dwe       = 1'b1;
            dwa       = na;
            dwd       = '0;
            lvl_nxt   = '0;
            state_nxt = S_ROOT;
          end
          KIND_ATTACH: begin
            dra       = nb;
            jwe       = 1'b1;
            jwa       = {na, LW'(0)};
            jwd       = nb;
            cur_nxt   = nb;
            lvl_nxt   = LW'(1);
            state_nxt = S_ATT_DEP;
          end
          KIND_QUERY: begin
            dra       = na;
            state_nxt = S_Q_DA;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      // root: every level points at the node itself
      S_ROOT: begin
        jwe = 1'b1;
        jwa = {na, lvl_r};
        jwd = na;
        lvl_nxt = lvl_r + 1'b1;
        if (lvl_r == LVL_TOP) state_nxt = S_DONE;
      end
      // attach: depth from parent, then fill levels upward
      S_ATT_DEP: begin
        dwe = 1'b1;
        dwa = na;
        dwd = depth_inc(drd_r);
        state_nxt = (LEVELS > 1) ? S_ATT_RD : S_DONE;
      end
      S_ATT_RD: begin
        jra_a     = {cur_r, lvl_r - 1'b1};
        state_nxt = S_ATT_WR;
      end
      S_ATT_WR: begin
        jwe     = 1'b1;
        jwa     = {na, lvl_r};
        jwd     = jrd_a;
        cur_nxt = jrd_a;
        if (lvl_r == LVL_TOP) begin
          state_nxt = S_DONE;
        end else begin
          lvl_nxt   = lvl_r + 1'b1;
          state_nxt = S_ATT_RD;
        end
      end
      // query: fetch both depths, order the pair
      S_Q_DA: begin
        dra       = nb;
        da_nxt    = drd_r;
        state_nxt = S_Q_DB;
      end
      S_Q_DB: begin
        db_nxt = drd_r;
        if (da_r > drd_r) begin
          x_nxt = nb;
          y_nxt = na;
          k_nxt = LEVELS'(da_r - drd_r);
        end else begin
          x_nxt = na;
          y_nxt = nb;
          k_nxt = LEVELS'(drd_r - da_r);
        end
        lvl_nxt   = LVL_TOP;
        state_nxt = S_Q_LIFT;
      end
      // lift the deeper node by the set bits of the depth gap
      S_Q_LIFT: begin
        if (k_r[lvl_r]) begin
          jra_a     = {y_r, lvl_r};
          state_nxt = S_Q_LIFT_WT;
        end else if (lvl_r == '0) begin
          state_nxt = S_Q_CMP;
        end else begin
          lvl_nxt = lvl_r - 1'b1;
        end
      end
      S_Q_LIFT_WT: begin
        y_nxt = jrd_a;
        if (lvl_r == '0) begin
          state_nxt = S_Q_CMP;
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = S_Q_LIFT;
        end
      end
      S_Q_CMP: begin
        if (x_r == y_r) begin
          anc_nxt   = x_r;
          state_nxt = S_Q_DEP;
        end else begin
          lvl_nxt   = LVL_TOP;
          state_nxt = S_Q_DESC;
        end
      end
      // descend both nodes while their ancestors differ
      S_Q_DESC: begin
        jra_a     = {x_r, lvl_r};
        jra_b     = {y_r, lvl_r};
        state_nxt = S_Q_DESC_WT;
      end
      S_Q_DESC_WT: begin
        if (jrd_a != jrd_b) begin
          x_nxt = jrd_a;
          y_nxt = jrd_b;
        end
        if (lvl_r == '0) begin
          state_nxt = S_Q_ANC;
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = S_Q_DESC;
        end
      end
      S_Q_ANC: begin
        jra_a     = {x_r, LW'(0)};
        state_nxt = S_Q_ANC_WT;
      end
      S_Q_ANC_WT: begin
        anc_nxt   = jrd_a;
        state_nxt = S_Q_DEP;
      end
      S_Q_DEP: begin
        dra       = anc_r;
        state_nxt = S_Q_DIST;
      end
      S_Q_DIST: begin
        res_anc_nxt  = ID_W'(anc_r);
        res_dist_nxt = (dsum > dtwice) ? dsum - dtwice : '0;
        state_nxt    = S_DONE;
      end
      // hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          out_anc_nxt   = res_anc_r;
          out_dist_nxt  = res_dist_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    red_s_r    <= red_s_nxt;
    lvl_r      <= lvl_nxt;
    cur_r      <= cur_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    anc_r      <= anc_nxt;
    k_r        <= k_nxt;
    da_r       <= da_nxt;
    db_r       <= db_nxt;
    res_anc_r  <= res_anc_nxt;
    res_dist_r <= res_dist_nxt;
    out_anc_r  <= out_anc_nxt;
    out_dist_r <= out_dist_nxt;
  end

  // depth memory
  always_ff @(posedge clk) begin
    if (dwe) begin
      dmem[dwa] <= dwd;
    end
    drd_r <= dmem[dra];
  end

  // jump table
  taqe_jump_mem #(
    .NODES  (NODES),
    .LEVELS (LEVELS),
    .NW     (NW),
    .LW     (LW)
  ) u_jump_mem (
    .clk       (clk),
    .wr_en     (jwe),
    .wr_addr   (jwa),
    .wr_data   (jwd),
    .rd_addr_a (jra_a),
    .rd_addr_b (jra_b),
    .rd_data_a (jrd_a),
    .rd_data_b (jrd_b)
  );

  // ports
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_dist_r, out_anc_r};

endmodule

// File: hw/rtl/taqe_jump_mem.sv
// jump table memory: one write port, two registered read ports
module taqe_jump_mem #(
  parameter int NODES  = taqe_pkg::NODES_DEF,
  parameter int LEVELS = taqe_pkg::LEVELS_DEF,
  parameter int NW     = $clog2(NODES),
  parameter int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [NW+LW-1:0] wr_addr,
  input  logic [NW-1:0]    wr_data,
  input  logic [NW+LW-1:0] rd_addr_a,
  input  logic [NW+LW-1:0] rd_addr_b,
  output logic [NW-1:0]    rd_data_a,
  output logic [NW-1:0]    rd_data_b
);
  import taqe_pkg::*;

  localparam int ENTRIES = NODES * (2 ** LW);

  logic [NW-1:0] mem [0:ENTRIES-1];
  logic [NW-1:0] rd_a_r;
  logic [NW-1:0] rd_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // two read ports, registered
  always_ff @(posedge clk) begin
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// File: bench/tb_tree_ancestor_query_engine.sv
// testbench for the tree ancestor query engine: directed rows, random trees and a deep chain
`timescale 1ns / 100ps

module tb_tree_ancestor_query_engine;
  import taqe_pkg::*;

  localparam int NODES  = NODES_DEF;
  localparam int LEVELS = LEVELS_DEF;

  // spare item kind, passes through with a zero result
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  // phase ends and the hold-off start count accepted items; hold-off and drain count clocks
  localparam int PHASE1_END   = 660;
  localparam int PHASE2_END   = 1320;
  localparam int TREE_END     = 720;
  localparam int STALL_AT     = 300;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic [ID_W-1:0]   anc;
    logic [DIST_W-1:0] path_len;
  } lca_result_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   node_a;
    logic [ID_W-1:0]   node_b;
    bit                typed;
    logic [ID_W-1:0]   anc;
    logic [DIST_W-1:0] path_len;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  // directed rows; typed results only where they are obvious
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{KIND_ROOT,   10'd0,     10'd1023,  1'b1, 10'd0,    11'd0},
    '{KIND_ROOT,   10'd1023,  10'd0,     1'b1, 10'd0,    11'd0},
    '{KIND_ATTACH, 10'd1023,  10'd0,     1'b1, 10'd0,    11'd0},
    '{KIND_ATTACH, 10'd5,     10'd1023,  1'b1, 10'd0,    11'd0},
    '{KIND_ATTACH, 10'd6,     10'd1023,  1'b1, 10'd0,    11'd0},
    '{KIND_QUERY,  10'd0,     10'd0,     1'b1, 10'd0,    11'd0},
    '{KIND_QUERY,  10'd1023,  10'd1023,  1'b1, 10'd1023, 11'd0},
    '{KIND_QUERY,  10'd1023,  10'd0,     1'b1, 10'd0,    11'd1},
    '{KIND_QUERY,  10'd0,     10'd5,     1'b1, 10'd0,    11'd2},
    '{KIND_QUERY,  10'd5,     10'd6,     1'b0, 10'd0,    11'd0},
    '{KIND_SPARE,  10'd1023,  10'd1023,  1'b1, 10'd0,    11'd0},
    '{KIND_SPARE,  10'h2aa,   10'h155,   1'b1, 10'd0,    11'd0},
    '{KIND_ATTACH, 10'd7,     10'd5,     1'b1, 10'd0,    11'd0},
    '{KIND_QUERY,  10'd7,     10'd6,     1'b0, 10'd0,    11'd0},
    '{KIND_QUERY,  10'd6,     10'd7,     1'b0, 10'd0,    11'd0},
    // re-hang a root with children below a deep node: distance goes negative
    '{KIND_ROOT,   10'd20,    10'd0,     1'b1, 10'd0,    11'd0},
    '{KIND_ATTACH, 10'd21,    10'd20,    1'b1, 10'd0,    11'd0},
    '{KIND_ATTACH, 10'd22,    10'd20,    1'b1, 10'd0,    11'd0},
    '{KIND_ATTACH, 10'd20,    10'd7,     1'b1, 10'd0,    11'd0},
    '{KIND_QUERY,  10'd21,    10'd22,    1'b0, 10'd0,    11'd0},
    '{KIND_QUERY,  10'd21,    10'd7,     1'b0, 10'd0,    11'd0},
    // node hung under itself
    '{KIND_ATTACH, 10'd6,     10'd6,     1'b1, 10'd0,    11'd0},
    '{KIND_QUERY,  10'd6,     10'd5,     1'b0, 10'd0,    11'd0}
  };

  logic                    clk;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;   // node_a[9:0], node_b[19:10]
  logic [KIND_W-1:0]       in_tuser   = '0;   // kind[1:0]
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;         // common_ancestor[9:0], distance[20:10]

  // predictor copy of the tables
  logic [ID_W-1:0]    jump_tbl  [NODES][LEVELS];
  logic [DEPTH_W-1:0] depth_tbl [NODES];

  // nodes written so far, so no unwritten entry is ever read
  bit                 written [NODES];
  logic [ID_W-1:0]    present_ids [$];

  lca_result_t        expected_lca [$];
  lca_result_t        head_lca;

  int sent_cnt    = 0;
  int fail_cnt    = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_left  = 0;
  bit stall_done  = 1'b0;

  tree_ancestor_query_engine #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // binary lifting: table update or lowest common ancestor with path length
  task automatic apply_tree_op(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] a,
                               input logic [ID_W-1:0] b, output lca_result_t res);
    logic [ID_W-1:0]    x, y, t, px, py;
    logic [DEPTH_W-1:0] d, k;
    int                 dd;
    res.anc      = '0;
    res.path_len = '0;
    case (kind)
      KIND_ROOT: begin
        for (int j = 0; j < LEVELS; j++) jump_tbl[a][j] = a;
        depth_tbl[a] = '0;
      end
      KIND_ATTACH: begin
        d = depth_tbl[b];
        depth_tbl[a] = (d >= DEPTH_MAX) ? DEPTH_MAX : d + 1'b1;
        jump_tbl[a][0] = b;
        for (int j = 1; j < LEVELS; j++) jump_tbl[a][j] = jump_tbl[jump_tbl[a][j-1]][j-1];
      end
      KIND_QUERY: begin
        x = a;
        y = b;
        if (depth_tbl[x] > depth_tbl[y]) begin
          t = x;
          x = y;
          y = t;
        end
        k = depth_tbl[y] - depth_tbl[x];
        // lift the deeper node to the same depth
        for (int j = LEVELS - 1; j >= 0; j--) begin
          if (k[j]) y = jump_tbl[y][j];
        end
        if (x == y) begin
          res.anc = x;
        end else begin
          // jump both while their ancestors differ
          for (int j = LEVELS - 1; j >= 0; j--) begin
            px = jump_tbl[x][j];
            py = jump_tbl[y][j];
            if (px != py) begin
              x = px;
              y = py;
            end
          end
          res.anc = jump_tbl[x][0];
        end
        dd = int'(depth_tbl[a]) + int'(depth_tbl[b]) - 2 * int'(depth_tbl[res.anc]);
        if (dd < 0) dd = 0;
        if (dd > 2047) dd = 2047;
        res.path_len = dd[DIST_W-1:0];
      end
      default: ;
    endcase
  endtask

  // offer one beat, wait for acceptance, then queue its expected result
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] a,
                           input logic [ID_W-1:0] b, input bit typed = 1'b0,
                           input logic [ID_W-1:0] t_anc = '0,
                           input logic [DIST_W-1:0] t_dist = '0);
    lca_result_t res;
    if (sent_cnt < PHASE1_END) begin
      tx_idle_pct = 14;
      rx_idle_pct = 69;
    end else if (sent_cnt < PHASE2_END) begin
      tx_idle_pct = 69;
      rx_idle_pct = 14;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - 2 * ID_W){1'b0}}, b, a};
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_tree_op(kind, a, b, res);
    if (typed) begin
      res.anc      = t_anc;
      res.path_len = t_dist;
    end
    expected_lca.push_back(res);
    if ((kind == KIND_ROOT || kind == KIND_ATTACH) && !written[a]) begin
      written[a] = 1'b1;
      present_ids.push_back(a);
    end
    sent_cnt++;
  endtask

  function automatic logic [ID_W-1:0] any_present();
    return present_ids[$urandom_range(present_ids.size() - 1)];
  endfunction

  // receiver: random ready, one long hold-off to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && sent_cnt >= STALL_AT) begin
      out_tready <= 1'b0;
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_lca.size() == 0) begin
        $error("result beat with nothing expected: common_ancestor %0d distance %0d",
               out_tdata[ID_W-1:0], out_tdata[ID_W +: DIST_W]);
        fail_cnt++;
      end else begin
        head_lca = expected_lca.pop_front();
        if (out_tdata[ID_W-1:0] !== head_lca.anc) begin
          $error("common_ancestor: expected %0d, got %0d", head_lca.anc, out_tdata[ID_W-1:0]);
          fail_cnt++;
        end
        if (out_tdata[ID_W +: DIST_W] !== head_lca.path_len) begin
          $error("distance: expected %0d, got %0d", head_lca.path_len,
                 out_tdata[ID_W +: DIST_W]);
          fail_cnt++;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [ID_W-1:0] root_id, child, parent, qa, qb, tip;
    int              ops, sel, base;
    logic [ID_W-1:0] branch [$];

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_item(dir_rows[r].kind, dir_rows[r].node_a, dir_rows[r].node_b,
                dir_rows[r].typed, dir_rows[r].anc, dir_rows[r].path_len);
    end

    // random trees: root, then mostly attaches and queries within the tree
    while (sent_cnt < TREE_END) begin
      root_id = ID_W'($urandom_range(NODES - 1));
      branch.delete();
      branch.push_back(root_id);
      send_item(KIND_ROOT, root_id, ID_W'($urandom_range(NODES - 1)));
      ops = $urandom_range(60, 8);
      repeat (ops) begin
        sel = $urandom_range(99);
        if (sel < 45) begin
          child  = ID_W'($urandom_range(NODES - 1));
          parent = (sel < 25) ? branch[$] : branch[$urandom_range(branch.size() - 1)];
          send_item(KIND_ATTACH, child, parent);
          branch.push_back(child);
        end else if (sel < 85) begin
          qa = branch[$urandom_range(branch.size() - 1)];
          qb = (sel < 78) ? branch[$urandom_range(branch.size() - 1)] : any_present();
          send_item(KIND_QUERY, qa, qb);
        end else if (sel < 90) begin
          send_item(KIND_SPARE, ID_W'($urandom_range(NODES - 1)),
                    ID_W'($urandom_range(NODES - 1)));
        end else if (sel < 95) begin
          // re-root a node that may have children
          send_item(KIND_ROOT, branch[$urandom_range(branch.size() - 1)],
                    ID_W'($urandom_range(NODES - 1)));
        end else begin
          // re-hang inside the tree, cycles allowed
          send_item(KIND_ATTACH, branch[$urandom_range(branch.size() - 1)],
                    branch[$urandom_range(branch.size() - 1)]);
        end
      end
    end

    // one chain through every node, deep enough to saturate the depth
    base = $urandom_range(NODES - 1);
    send_item(KIND_ROOT, base[ID_W-1:0], ID_W'($urandom_range(NODES - 1)));
    for (int i = 1; i < NODES; i++) begin
      send_item(KIND_ATTACH, ID_W'((base + i) % NODES), ID_W'((base + i - 1) % NODES));
      if ($urandom_range(7) == 0) begin
        qa = ID_W'((base + $urandom_range(i)) % NODES);
        qb = ($urandom_range(1) == 0) ? ID_W'((base + $urandom_range(i)) % NODES)
                                      : any_present();
        send_item(KIND_QUERY, qa, qb);
      end
      if ($urandom_range(39) == 0)
        send_item(KIND_SPARE, ID_W'($urandom_range(NODES - 1)),
                  ID_W'($urandom_range(NODES - 1)));
    end

    // hang nodes below the deepest one: depth stays at its maximum
    tip = ID_W'((base + NODES - 1) % NODES);
    send_item(KIND_ATTACH, tip, tip);
    repeat (3) begin
      child = ID_W'((base + $urandom_range(5)) % NODES);
      send_item(KIND_ATTACH, child, tip);
      send_item(KIND_QUERY, child, tip);
    end
    repeat (20) begin
      qa = ($urandom_range(1) == 0) ? tip : any_present();
      send_item(KIND_QUERY, qa, any_present());
    end

    in_tvalid <= 1'b0;
    while (expected_lca.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb_tree_ancestor_query_engine passed");
    end else begin
      $display("tb_tree_ancestor_query_engine failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #4ms;
    $display("tb_tree_ancestor_query_engine failed");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/taqe_pkg.sv
hw/rtl/taqe_jump_mem.sv
hw/rtl/tree_ancestor_query_engine.sv
bench/tb_tree_ancestor_query_engine.sv
